/* sv/utf8sd_pkg.sv */
// Package for the UTF-8 stream decoder.
// Holds the error code type, field widths, the sequence length and control range constants and the result word.
// Has no dependencies.

package utf8sd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned REM_W  = 2;

    // Error codes reported with each result word
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_LEAD = 2'd1,
        ERR_ZERO     = 2'd2,
        ERR_TRUNC    = 2'd3
    } err_code_t;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // Control code point ranges (C0 below 0x20, C1 from 0x80 up to 0x9F)
    localparam logic [CP_W-1:0] C0_END   = 21'h000020;
    localparam logic [CP_W-1:0] C1_START = 21'h000080;
    localparam logic [CP_W-1:0] C1_END   = 21'h0000A0;

    // One decoded result word
    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_length;
        err_code_t        error_code;
        logic             is_control;
    } result_t;

endpackage

/* sv/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: input register, decode logic,
// sequence state and result register with valid/ready on both sides.
// Depends on utf8sd_pkg.

// Takes one byte per cycle while in_ready is high and returns at most one
// result word per byte: a code point with its sequence length, or an error
// (bad lead byte, zero byte, or a sequence cut short by the byte flagged
// last). A byte that only extends a sequence gives no result. The decoder
// sustains one byte per clock unless in_ready drops. An accepted byte sits in
// the input register while the decode logic works on it, and the result
// register loads when the held byte advances. The result register frees the
// input side, so bytes keep flowing while a result waits, and in_ready drops
// only when a result is held and not taken and a byte that would produce
// another one is waiting behind it.

module utf8_stream_decoder
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]    data_byte,
    input  logic                             last,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [utf8sd_pkg::CP_W-1:0]      codepoint,
    output logic [utf8sd_pkg::LEN_W-1:0]     seq_length,
    output logic [1:0]                       error_code,
    output logic                             is_control
);

    // Input register
    logic                          in_vld_reg;
    logic [utf8sd_pkg::BYTE_W-1:0] byte_reg;
    logic                          last_reg;

    // Sequence state
    logic [utf8sd_pkg::REM_W-1:0]  rem_reg,  rem_next;
    logic [utf8sd_pkg::LEN_W-1:0]  total_reg, total_next;
    logic [utf8sd_pkg::CP_W-1:0]   partial_reg, partial_next;

    // Result register
    logic                          out_vld_reg;
    utf8sd_pkg::result_t           res_reg, res_next;

    logic                          has_result;
    logic                          advance;
    logic                          out_free;
    logic [utf8sd_pkg::CP_W-1:0]   shifted;
    logic [utf8sd_pkg::CP_W-1:0]   cp_ok;
    logic [utf8sd_pkg::LEN_W-1:0]  len_ok;
    utf8sd_pkg::err_code_t         err;

    // Decode the held byte against the sequence state
    always_comb
    begin
        rem_next     = rem_reg;
        total_next   = total_reg;
        partial_next = partial_reg;
        has_result   = 1'b0;
        err          = utf8sd_pkg::ERR_NONE;
        cp_ok        = '0;
        len_ok       = utf8sd_pkg::LEN_NONE;
        shifted      = {partial_reg[utf8sd_pkg::CP_W-7:0], byte_reg[5:0]};

        if (rem_reg == '0)
        begin
            case (byte_reg) inside
                8'h00:
                begin
                    has_result = 1'b1;
                    err        = utf8sd_pkg::ERR_ZERO;
                end
                [8'h01:8'h7F]:
                begin
                    has_result = 1'b1;
                    cp_ok      = {{(utf8sd_pkg::CP_W-utf8sd_pkg::BYTE_W){1'b0}}, byte_reg};
                    len_ok     = utf8sd_pkg::LEN_ONE;
                end
                [8'hC0:8'hDF]:
                begin
                    rem_next     = 2'd1;
                    total_next   = utf8sd_pkg::LEN_TWO;
                    partial_next = {{(utf8sd_pkg::CP_W-5){1'b0}}, byte_reg[4:0]};
                end
                [8'hE0:8'hEF]:
                begin
                    rem_next     = 2'd2;
                    total_next   = utf8sd_pkg::LEN_THREE;
                    partial_next = {{(utf8sd_pkg::CP_W-4){1'b0}}, byte_reg[3:0]};
                end
                [8'hF0:8'hF7]:
                begin
                    rem_next     = 2'd3;
                    total_next   = utf8sd_pkg::LEN_FOUR;
                    partial_next = {{(utf8sd_pkg::CP_W-3){1'b0}}, byte_reg[2:0]};
                end
                default:
                begin
                    // Stray continuation or lead of F8 and above
                    has_result = 1'b1;
                    err        = utf8sd_pkg::ERR_BAD_LEAD;
                end
            endcase

            // A lead byte flagged last cannot complete
            if (!has_result && last_reg)
            begin
                has_result = 1'b1;
                err        = utf8sd_pkg::ERR_TRUNC;
            end
        end
        else if (byte_reg == '0)
        begin
            has_result = 1'b1;
            err        = utf8sd_pkg::ERR_ZERO;
        end
        else
        begin
            rem_next     = rem_reg - 2'd1;
            partial_next = shifted;
            if (rem_reg == 2'd1)
            begin
                has_result = 1'b1;
                cp_ok      = shifted;
                len_ok     = total_reg;
            end
            else if (last_reg)
            begin
                has_result = 1'b1;
                err        = utf8sd_pkg::ERR_TRUNC;
            end
        end

        // Clear the state whenever a result closes the sequence
        if (has_result)
        begin
            rem_next     = '0;
            total_next   = '0;
            partial_next = '0;
        end
    end

    // Form the result word
    always_comb
    begin
        res_next.error_code = err;
        res_next.codepoint  = cp_ok;
        res_next.seq_length = len_ok;
        res_next.is_control = (err == utf8sd_pkg::ERR_NONE) &&
                              ((cp_ok < utf8sd_pkg::C0_END) ||
                               (cp_ok >= utf8sd_pkg::C1_START &&
                                cp_ok < utf8sd_pkg::C1_END));
    end

    // Advance the held byte when its result, if any, has room
    assign out_free = !out_vld_reg || out_ready;
    assign advance  = in_vld_reg && (!has_result || out_free);
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= last;
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            total_reg   <= '0;
            partial_reg <= '0;
        end
        else if (advance)
        begin
            rem_reg     <= rem_next;
            total_reg   <= total_next;
            partial_reg <= partial_next;
        end
    end

    // Result register: load on a new result, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign codepoint  = res_reg.codepoint;
    assign seq_length = res_reg.seq_length;
    assign error_code = res_reg.error_code;
    assign is_control = res_reg.is_control;

endmodule
